>>> rtl/b64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    localparam int unsigned GrpChars = 6;

    localparam logic [7:0] CharCr  = 8'h0d;
    localparam logic [7:0] CharLf  = 8'h0a;
    localparam logic [7:0] CharPad = 8'h3d;

    // up to six characters, first one in chars[0]
    typedef struct packed {
        logic [GrpChars-1:0][7:0] chars;
        logic [2:0]               n;
        logic                     fin;
    } t_grp;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2b;
        end else begin
            c = 8'h2f;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64e_enc.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_enc (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data,
    input  wire logic          i_final,
    input  wire logic [5:0]    i_gpl,
    output b64e_pkg::t_grp     o_grp,
    output logic               o_grp_valid,
    input  wire logic          i_grp_take
);

    logic [7:0]     r_first;
    logic [7:0]     r_second;
    logic [1:0]     r_pc;
    logic [5:0]     r_gol;
    logic           r_gv;
    b64e_pkg::t_grp r_grp;

    logic [7:0]     n_first;
    logic [7:0]     n_second;
    logic [1:0]     n_pc;
    logic [5:0]     n_gol;
    b64e_pkg::t_grp n_grp;

    logic       w_acc;
    logic [5:0] w_gol_inc;
    logic       w_wrap;

    assign o_ready   = !r_gv || i_grp_take;
    assign w_acc     = i_valid && o_ready;
    assign w_gol_inc = r_gol + 6'd1;
    assign w_wrap    = (i_gpl != 6'd0) && (w_gol_inc >= i_gpl);

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_pc     = r_pc;
        n_gol    = r_gol;
        n_grp    = '0;
        if (r_pc[1]) begin
            n_grp.chars[0] = b64e_pkg::sextet_char(r_first[7:2]);
            n_grp.chars[1] = b64e_pkg::sextet_char({r_first[1:0], r_second[7:4]});
            n_grp.chars[2] = b64e_pkg::sextet_char({r_second[3:0], i_data[7:6]});
            n_grp.chars[3] = b64e_pkg::sextet_char(i_data[5:0]);
            n_grp.chars[4] = b64e_pkg::CharCr;
            n_grp.chars[5] = b64e_pkg::CharLf;
            n_grp.n        = w_wrap ? 3'd6 : 3'd4;
            n_gol          = w_wrap ? 6'd0 : w_gol_inc;
            n_pc           = 2'd0;
        end else if (i_final) begin
            if (!r_pc[0]) begin
                n_grp.chars[0] = b64e_pkg::sextet_char(i_data[7:2]);
                n_grp.chars[1] = b64e_pkg::sextet_char({i_data[1:0], 4'b0000});
                n_grp.chars[2] = b64e_pkg::CharPad;
            end else begin
                n_grp.chars[0] = b64e_pkg::sextet_char(r_first[7:2]);
                n_grp.chars[1] = b64e_pkg::sextet_char({r_first[1:0], i_data[7:4]});
                n_grp.chars[2] = b64e_pkg::sextet_char({i_data[3:0], 2'b00});
            end
            n_grp.chars[3] = b64e_pkg::CharPad;
            n_grp.n        = 3'd4;
        end else begin
            if (!r_pc[0]) begin
                n_first = i_data;
            end else begin
                n_second = i_data;
            end
            n_pc = r_pc + 2'd1;
        end
        if (i_final) begin
            n_gol = 6'd0;
            n_pc  = 2'd0;
        end
        n_grp.fin = i_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_pc     <= '0;
            r_gol    <= '0;
            r_gv     <= 1'b0;
        end else begin
            if (w_acc) begin
                r_first  <= n_first;
                r_second <= n_second;
                r_pc     <= n_pc;
                r_gol    <= n_gol;
            end
            if (w_acc && (n_grp.n != 3'd0)) begin
                r_gv <= 1'b1;
            end else if (i_grp_take) begin
                r_gv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (n_grp.n != 3'd0)) begin
            r_grp <= n_grp;
        end
    end

    assign o_grp       = r_grp;
    assign o_grp_valid = r_gv;

`ifndef NO_ASSERTIONS
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc != 2'd3)
        else $error("pending count out of range");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_final |=> (r_pc == 2'd0) && (r_gol == 6'd0) && r_gv)
        else $error("final item did not clear line state");
`endif

endmodule

`default_nettype wire

>>> rtl/b64e_ser.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_ser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire b64e_pkg::t_grp i_grp,
    input  wire logic          i_grp_valid,
    output logic               o_grp_take,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [7:0]         o_tdata,
    output logic               o_run_last,
    output logic               o_msg_end
);

    logic [b64e_pkg::GrpChars-1:0][7:0] r_chars;
    logic [2:0]                         r_left;
    logic                               r_fin;
    logic                               r_valid;

    logic w_last;
    logic w_free;

    assign w_last     = (r_left == 3'd1);
    assign w_free     = !r_valid || (i_tready && w_last);
    assign o_grp_take = w_free && i_grp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (w_free) begin
            r_valid <= i_grp_valid;
            r_left  <= i_grp_valid ? i_grp.n : 3'd0;
        end else if (i_tready) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grp_take) begin
            r_chars <= i_grp.chars;
            r_fin   <= i_grp.fin;
        end else if (r_valid && i_tready) begin
            r_chars <= {8'h00, r_chars[b64e_pkg::GrpChars-1:1]};
        end
    end

    assign o_tvalid   = r_valid;
    assign o_tdata    = r_chars[0];
    assign o_run_last = w_last;
    assign o_msg_end  = w_last && r_fin;

`ifndef NO_ASSERTIONS
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_left != 3'd0) && (r_left <= 3'd6))
        else $error("item held with bad character count");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && o_msg_end |-> o_run_last)
        else $error("message end without run end");
`endif

endmodule

`default_nettype wire

>>> rtl/base64_line_wrapped_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Base64 encoder with MIME-style line wrapping. Raw bytes enter on the slave
// stream, one per item, tlast on the final byte of a message; characters
// leave on the master stream one per cycle while m_axis_tready is high. A byte
// that only gets buffered yields no characters; a byte that completes a group
// of three, or is final, yields four characters (six with CR LF at the end of
// a line), so the rate is set by the output serializer. An encoded group is
// held in a register between encoder and serializer, so the next byte is
// taken while the previous group still drains. groups_per_line (APB address
// 0, reset 19) sets the groups per line; 0 turns wrapping off. Empty messages
// cannot be encoded.
module base64_line_wrapped_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // final_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] char_code
    output logic             m_axis_tuser,   // [0] run_last
    output logic             m_axis_tlast,   // message_end

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [5:0]     r_gpl;
    b64e_pkg::t_grp w_grp;
    logic           w_grp_valid;
    logic           w_grp_take;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl <= 6'd19;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_gpl <= pwdata[5:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {26'd0, r_gpl};

    b64e_enc u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_final     (s_axis_tlast),
        .i_gpl       (r_gpl),
        .o_grp       (w_grp),
        .o_grp_valid (w_grp_valid),
        .i_grp_take  (w_grp_take)
    );

    b64e_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (w_grp),
        .i_grp_valid (w_grp_valid),
        .o_grp_take  (w_grp_take),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_run_last  (m_axis_tuser),
        .o_msg_end   (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> tb/b64_stream_checker.sv
`timescale 1ns / 1ps

module b64_stream_checker #(
    parameter logic [2:0] GplAddr = 3'd0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,

    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_out_char,
    input  wire logic        i_out_run_last,
    input  wire logic        i_out_msg_end,

    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,

    output int               o_fail_cnt,
    output int               o_pending,
    output int               o_char_cnt,
    output int               o_brk_cnt
);

    localparam logic [5:0] GplReset = 6'd19;
    localparam logic [511:0] B64Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] code;
        logic       run_last;
        logic       msg_end;
    } t_enc_char;

    t_enc_char  exp_chars[$];
    logic [5:0] gpl;
    logic [7:0] held_a;
    logic [7:0] held_b;
    logic [1:0] held_cnt;
    logic [5:0] line_grps;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64Alphabet[511 - 8 * int'(v) -: 8];
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] cs [6];
        logic [1:0] cnt;
        t_enc_char  ec;
        int         n;
        int         k;
        n = 0;
        cnt = (held_cnt >= 2'd2) ? 2'd2 : held_cnt;
        if (cnt == 2'd2) begin
            cs[0] = b64_char(held_a[7:2]);
            cs[1] = b64_char({held_a[1:0], held_b[7:4]});
            cs[2] = b64_char({held_b[3:0], b[7:6]});
            cs[3] = b64_char(b[5:0]);
            n = 4;
            line_grps = line_grps + 6'd1;
            if (gpl != 6'd0 && line_grps >= gpl) begin
                cs[4] = b64e_pkg::CharCr;
                cs[5] = b64e_pkg::CharLf;
                n = 6;
                line_grps = 6'd0;
            end
            held_cnt = 2'd0;
        end else if (fin) begin
            if (cnt == 2'd0) begin
                cs[0] = b64_char(b[7:2]);
                cs[1] = b64_char({b[1:0], 4'b0000});
                cs[2] = b64e_pkg::CharPad;
            end else begin
                cs[0] = b64_char(held_a[7:2]);
                cs[1] = b64_char({held_a[1:0], b[7:4]});
                cs[2] = b64_char({b[3:0], 2'b00});
            end
            cs[3] = b64e_pkg::CharPad;
            n = 4;
            held_cnt = 2'd0;
        end else begin
            if (cnt == 2'd0) begin
                held_a = b;
            end else begin
                held_b = b;
            end
            held_cnt = cnt + 2'd1;
        end
        if (fin) begin
            line_grps = 6'd0;
            held_cnt = 2'd0;
        end
        for (k = 0; k < n; k++) begin
            ec.code     = cs[k];
            ec.run_last = (k == n - 1);
            ec.msg_end  = (k == n - 1) && fin;
            exp_chars.push_back(ec);
        end
    endtask

    task automatic check_char();
        t_enc_char want;
        if (exp_chars.size() == 0) begin
            $error("unexpected char_code %02h with nothing pending", i_out_char);
            o_fail_cnt++;
        end else begin
            want = exp_chars.pop_front();
            if (i_out_char !== want.code) begin
                $error("char_code: expected %02h, got %02h", want.code, i_out_char);
                o_fail_cnt++;
            end
            if (i_out_run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, i_out_run_last);
                o_fail_cnt++;
            end
            if (i_out_msg_end !== want.msg_end) begin
                $error("message_end: expected %0b, got %0b", want.msg_end, i_out_msg_end);
                o_fail_cnt++;
            end
            o_char_cnt++;
            if (want.code == b64e_pkg::CharCr) begin
                o_brk_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gpl = GplReset;
            held_a = 8'h00;
            held_b = 8'h00;
            held_cnt = 2'd0;
            line_grps = 6'd0;
            exp_chars.delete();
            o_fail_cnt = 0;
            o_char_cnt = 0;
            o_brk_cnt = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                encode_byte(i_in_byte, i_in_last);
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == GplAddr) begin
                gpl = i_pwdata[5:0];
            end
            if (i_out_valid && i_out_ready) begin
                check_char();
            end
        end
        o_pending = exp_chars.size();
    end

endmodule

>>> tb/tb_base64_line_wrapped_encoder.sv
`timescale 1ns / 1ps

module tb_base64_line_wrapped_encoder;

    localparam logic [2:0] AddrGroupsPerLine = 3'd0;
    localparam int IdleCycles  = 8;
    localparam int DrainCycles = 24;
    localparam int HoldCycles  = 300;
    localparam int WdogLimit   = 4000;
    localparam int PhaseBytes  = 24;

    typedef enum int {RxOpen, RxCoin, RxSlow, RxToggle} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // final_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] char_code
    logic        m_axis_tuser;           // [0] run_last
    logic        m_axis_tlast;           // message_end

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_cnt;
    int          n_pending;
    int          char_cnt;
    int          brk_cnt;

    int          burst_left = 0;
    int          n_bytes = 0;
    int          n_msgs = 0;
    int          n_settings = 0;
    int          stall_cycles = 0;
    logic        hold_req = 1'b0;
    logic [7:0]  byte_buf[$];

    always #2 i_clk = ~i_clk;

    base64_line_wrapped_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    b64_stream_checker #(
        .GplAddr (AddrGroupsPerLine)
    ) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_byte      (s_axis_tdata),
        .i_in_last      (s_axis_tlast),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_char     (m_axis_tdata),
        .i_out_run_last (m_axis_tuser),
        .i_out_msg_end  (m_axis_tlast),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_cnt     (fail_cnt),
        .o_pending      (n_pending),
        .o_char_cnt     (char_cnt),
        .o_brk_cnt      (brk_cnt)
    );

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WdogLimit) begin
                $display("FAIL base64_line_wrapped_encoder");
                $finish;
            end
        end
    end

    // output back-pressure: random modes, plus one long hold on request
    initial begin : rx_stall
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold_left;
        rx_mode = RxOpen;
        mode_left = 0;
        hold_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (rx_mode)
                    RxOpen:   m_axis_tready <= 1'b1;
                    RxCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RxSlow:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:  m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        n_bytes++;
        if (fin) begin
            n_msgs++;
        end
    endtask

    task automatic send_buf(input logic fin);
        int k;
        for (k = 0; k < byte_buf.size(); k++) begin
            send_byte(byte_buf[k], fin && (k == byte_buf.size() - 1));
        end
    endtask

    task automatic send_random_msg(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic wait_idle(input int extra);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_line_len(input logic [5:0] gpl);
        logic [31:0] wd;
        wd = $urandom;
        wd[5:0] = gpl;
        wait_idle(IdleCycles);
        apb_write(AddrGroupsPerLine, wd);
        n_settings++;
    endtask

    initial begin
        logic [5:0] gpl_plan [6];
        int         ph;
        int         len;
        int         phase_bytes;

        gpl_plan = '{6'd3, 6'd63, 6'd0, 6'd1, 6'd19, 6'd2};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default line length: one- and two-byte tails, final byte closing a group
        byte_buf = '{8'h00};
        send_buf(1'b1);
        byte_buf = '{8'hff};
        send_buf(1'b1);
        byte_buf = '{8'h00, 8'hff};
        send_buf(1'b1);
        byte_buf = '{8'hff, 8'h00, 8'h80};
        send_buf(1'b1);

        // one group per line: CR LF after every group, the final one too
        set_line_len(6'd1);
        byte_buf = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc};
        send_buf(1'b1);

        // line length lowered below the running count in mid-message
        set_line_len(6'd5);
        byte_buf = '{8'hfc, 8'h03, 8'hf0, 8'h0f, 8'haa, 8'h55, 8'h01, 8'h02, 8'h04};
        send_buf(1'b0);
        set_line_len(6'd2);
        byte_buf = '{8'h3f, 8'hc0, 8'h7e};
        send_buf(1'b1);

        for (ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                gpl_plan[ph] = 6'($urandom_range(4, 62));
            end
            set_line_len(gpl_plan[ph]);
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            phase_bytes = 0;
            while (phase_bytes < PhaseBytes) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(1, 12);
                send_random_msg(len);
                phase_bytes += len;
            end
        end

        wait_idle(DrainCycles);
        $display("Encoded %0d bytes in %0d messages under %0d line-length settings.",
                 n_bytes, n_msgs, n_settings);
        $display("Checked %0d characters including %0d line breaks; %0d mismatches.",
                 char_cnt, brk_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("PASS base64_line_wrapped_encoder");
        end else begin
            $display("FAIL base64_line_wrapped_encoder");
        end
        $finish;
    end

endmodule

>>> base64_line_wrapped_encoder.f
rtl/b64e_pkg.sv
rtl/b64e_enc.sv
rtl/b64e_ser.sv
rtl/base64_line_wrapped_encoder.sv
tb/b64_stream_checker.sv
tb/tb_base64_line_wrapped_encoder.sv
